### design/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, register indexes and helpers for the cave smoothing block.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CFG_W      = 11;   // widest configuration register
    localparam int THR_W      = 4;
    localparam int MIN_SIZE   = 3;
    localparam int SIZE_RESET = 1024;
    localparam int THR_RESET  = 4;

    localparam int COORD_W = 10;     // width of out_row and out_col on the port

    typedef enum logic [1:0] {
        REG_MAP_ROWS       = 2'd0,
        REG_MAP_COLS       = 2'd1,
        REG_OPEN_THRESHOLD = 2'd2
    } cfg_index_t;

    // Saturate a written map size into MIN_SIZE..hi.
    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
        int x;
        x = int'(v);
        if (x < MIN_SIZE) begin
            return MIN_SIZE;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

### design/cas_ram.sv
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/cave_automaton_smoothing_top.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_top
// One generation of a 3x3 cave smoothing automaton over a raster cell stream.
// Throughput: one cell per cycle while the output queue has room (s_tready);
// the column memory is read and written back once per cell, at different
// addresses, so items follow back to back. The cell that completes a window
// passes memory read, then output queue, to m_; results lag input by one row + 1.
// Reset: sizes and threshold return to defaults, positions to zero; the
// line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cave_automaton_smoothing_top
    import cas_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    // input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // [0] cell_open, [7:1] zero
    input  wire logic             s_tuser,    // [0] flush
    // result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [23:0]      m_tdata,    // [0] next_open, [10:1] out_row,
                                              // [20:11] out_col, [23:21] zero
    output logic                  m_tlast     // frame_last
);

    localparam int AW  = $clog2(MAX_COLS);
    localparam int CW  = $clog2(MAX_COLS + 1);
    // the input row runs up to rows + 1 during the drain words
    localparam int RW  = $clog2(MAX_ROWS + 2);
    localparam int ORW = $clog2(MAX_ROWS);

    localparam logic [1:0] Q_LAST = 2'd2;
    localparam logic [1:0] Q_FULL = 2'd3;

    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               open;
    } res_t;

    // configuration
    logic [RW-1:0]    rows_reg;
    logic [CW-1:0]    cols_reg;
    logic [THR_W-1:0] thr_reg;
    logic             restart;

    // positions
    logic [AW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [AW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;

    logic [CW-1:0] cols_m1;
    logic [RW-1:0] rows_m1;
    logic          accept, in_frame, emit, in_col_end, out_col_end, last, border;

    // memory stage
    logic               p1_valid_reg, p1_emit_reg, p1_cell_reg;
    logic               p1_border_reg, p1_last_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic [COORD_W-1:0] p1_row_reg, p1_col_reg;
    logic [1:0]         rd_data;

    // window: bit 0 top, bit 1 middle, bit 2 bottom row
    logic [2:0]       win_mid_reg, win_right_reg, win_new;
    logic [THR_W-1:0] count;
    logic             next_open;

    // output queue
    res_t       q_mem_reg [3];
    logic [1:0] q_wptr_reg, q_rptr_reg, q_occ_reg;
    logic       push, pop;

    // ---------------- configuration ----------------
    assign restart = cfg_we && (cfg_index == REG_MAP_ROWS || cfg_index == REG_MAP_COLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= RW'(clamp_size(CFG_W'(SIZE_RESET), MAX_ROWS));
            cols_reg <= CW'(clamp_size(CFG_W'(SIZE_RESET), MAX_COLS));
            thr_reg  <= THR_W'(THR_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAP_ROWS:       rows_reg <= RW'(clamp_size(cfg_wdata, MAX_ROWS));
                REG_MAP_COLS:       cols_reg <= CW'(clamp_size(cfg_wdata, MAX_COLS));
                REG_OPEN_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position tracking at accept ----------------
    assign cols_m1     = cols_reg - CW'(1);
    assign rows_m1     = rows_reg - RW'(1);
    assign accept      = s_tvalid && s_tready;
    assign in_frame    = in_row_reg < rows_reg;
    assign emit        = (in_row_reg > RW'(1)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign in_col_end  = CW'(in_col_reg) == cols_m1;
    assign out_col_end = CW'(out_col_reg) == cols_m1;
    assign last        = out_col_end && (RW'(out_row_reg) == rows_m1);
    assign border      = (out_row_reg == '0) || (RW'(out_row_reg) >= rows_m1) ||
                         (out_col_reg == '0) || out_col_end;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (accept) begin
            if (emit && last) begin
                // frame done: wait for the next frame
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (in_col_end) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end else begin
                    in_col_next = in_col_reg + AW'(1);
                end
                if (emit) begin
                    if (out_col_end) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ORW'(1);
                    end else begin
                        out_col_next = out_col_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p1_emit_reg  <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            p1_valid_reg <= accept;
            p1_emit_reg  <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            // a flush inside the frame counts as solid rock
            p1_cell_reg   <= in_frame && !s_tuser && s_tdata[0];
            p1_addr_reg   <= in_col_reg;
            p1_border_reg <= border;
            p1_last_reg   <= last;
            p1_row_reg    <= COORD_W'(out_row_reg);
            p1_col_reg    <= COORD_W'(out_col_reg);
        end
    end

    // ---------------- column memory: {row - 2, row - 1} per column ----------------
    cas_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata ({rd_data[0], p1_cell_reg}),
        .raddr (in_col_reg),
        .rdata (rd_data)
    );

    // ---------------- window and rule ----------------
    assign win_new = {p1_cell_reg, rd_data[0], rd_data[1]};

    assign count = THR_W'(win_mid_reg[0]) + THR_W'(win_mid_reg[1]) + THR_W'(win_mid_reg[2]) +
                   THR_W'(win_right_reg[0]) + THR_W'(win_right_reg[2]) +
                   THR_W'(win_new[0]) + THR_W'(win_new[1]) + THR_W'(win_new[2]);

    // the previous right column holds the emitted cell in its middle row
    assign next_open = p1_border_reg ? win_right_reg[1] : (count > thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_mid_reg   <= '0;
            win_right_reg <= '0;
        end else if (p1_valid_reg) begin
            win_mid_reg   <= win_right_reg;
            win_right_reg <= win_new;
        end
    end

    // ---------------- output queue ----------------
    assign push = p1_emit_reg;
    assign pop  = m_tvalid && m_tready;

    // leave room for the word still in the memory stage
    assign s_tready = (q_occ_reg != Q_FULL) && !(q_occ_reg == Q_LAST && push);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[q_wptr_reg] <= '{last: p1_last_reg, col: p1_col_reg,
                                       row: p1_row_reg, open: next_open};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wptr_reg <= '0;
            q_rptr_reg <= '0;
            q_occ_reg  <= '0;
        end else begin
            if (push) begin
                q_wptr_reg <= (q_wptr_reg == Q_LAST) ? 2'd0 : q_wptr_reg + 2'd1;
            end
            if (pop) begin
                q_rptr_reg <= (q_rptr_reg == Q_LAST) ? 2'd0 : q_rptr_reg + 2'd1;
            end
            if (push && !pop) begin
                q_occ_reg <= q_occ_reg + 2'd1;
            end else if (pop && !push) begin
                q_occ_reg <= q_occ_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = q_occ_reg != 2'd0;
    assign m_tdata  = {3'b000, q_mem_reg[q_rptr_reg].col, q_mem_reg[q_rptr_reg].row,
                       q_mem_reg[q_rptr_reg].open};
    assign m_tlast  = q_mem_reg[q_rptr_reg].last;

endmodule

`default_nettype wire
